// ===== design/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg: shared definitions for the double-ended priority queue
// Operation codes, status codes, field widths and the cell control struct.
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int unsigned CAPACITY_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_MAX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Broadcast control, seen by every cell of the chain at the same time.
  typedef struct packed {
    logic ins;  // insert the broadcast entry at its sorted place
    logic shl;  // shift the whole chain one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== design/depq_cell.sv =====
// ----------------------------------------------------------------------------
// depq_cell: one slot of the sorted chain
// Holds one key and payload, compares against the broadcast key and takes
// its own, the new, the left or the right entry.
// ----------------------------------------------------------------------------
module depq_cell #(
  parameter int unsigned PAYLOAD_BITS = depq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                               clk_i,
  input  depq_pkg::cell_ctrl_t               ctrl_i,
  input  logic                               valid_i,
  input  logic signed [depq_pkg::KEY_W-1:0]  new_key_i,
  input  logic        [PAYLOAD_BITS-1:0]     new_pay_i,
  input  logic                               left_lt_i,
  input  logic signed [depq_pkg::KEY_W-1:0]  left_key_i,
  input  logic        [PAYLOAD_BITS-1:0]     left_pay_i,
  input  logic signed [depq_pkg::KEY_W-1:0]  right_key_i,
  input  logic        [PAYLOAD_BITS-1:0]     right_pay_i,
  output logic                               lt_o,
  output logic signed [depq_pkg::KEY_W-1:0]  key_o,
  output logic        [PAYLOAD_BITS-1:0]     pay_o
);

  logic signed [depq_pkg::KEY_W-1:0] key_q, key_d;
  logic        [PAYLOAD_BITS-1:0]    pay_q, pay_d;

  // The stored key sorts strictly before the new one, so equal keys let the
  // new entry in ahead of them.
  assign lt_o = valid_i && (key_q < new_key_i);

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.ins && !lt_o) begin
      if (left_lt_i) begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end else begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end
    end else if (ctrl_i.shl) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

// ===== design/double_ended_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top: sorted chain double-ended priority queue
// Keeps up to CAPACITY keyed entries in ascending order in a row of cells;
// inserts, deletes the minimum or maximum, or queries, one item at a time.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                | Payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_ready_o  | mode_i, key_i, payload_i
//  out     | out_valid_o / out_ready_i| status_o, removed_payload_o,
//          |                          | removed_key_o, entry_count_o,
//          |                          | smallest_key_o, largest_key_o
//
// Each item passes the update stage, where every cell compares and shifts in
// parallel, and then the readout stage, where the smallest and largest keys
// are read out of the updated chain into the output register. A new item is
// not accepted while the previous one still waits in the readout stage.
// Reset clears the entry count and the handshake flags; cell contents are
// not reset, since only cells below the count are ever read.
// While a result waits in the output register, one more item may be
// accepted; it then holds in the readout stage and in_ready_o stays low.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_top #(
  parameter int unsigned CAPACITY     = depq_pkg::CAPACITY_DEF,
  parameter int unsigned PAYLOAD_BITS = depq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [depq_pkg::MODE_W-1:0]   mode_i,
  input  logic signed [depq_pkg::KEY_W-1:0]    key_i,
  input  logic        [PAYLOAD_BITS-1:0]       payload_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [depq_pkg::STATUS_W-1:0] status_o,
  output logic        [PAYLOAD_BITS-1:0]       removed_payload_o,
  output logic signed [depq_pkg::KEY_W-1:0]    removed_key_o,
  output logic        [depq_pkg::COUNT_W-1:0]  entry_count_o,
  output logic signed [depq_pkg::KEY_W-1:0]    smallest_key_o,
  output logic signed [depq_pkg::KEY_W-1:0]    largest_key_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned KW   = depq_pkg::KEY_W;

  // Cell array wiring.
  logic signed [KW-1:0]           cell_key [CAPACITY];
  logic        [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];
  logic        [CAPACITY-1:0]     cell_lt;
  logic        [CAPACITY-1:0]     cell_valid;
  logic        [CAPACITY-1:0]     cell_last;
  depq_pkg::cell_ctrl_t           ctrl;

  // Control and result registers.
  logic [CntW-1:0]               count_q, count_d;
  logic                          pend_q, pend_d;
  logic [depq_pkg::STATUS_W-1:0] stat_q, stat_d;
  logic signed [KW-1:0]          rkey_q, rkey_d;
  logic [PAYLOAD_BITS-1:0]       rpay_q, rpay_d;
  logic                          oval_q, oval_d;
  logic [depq_pkg::STATUS_W-1:0] ostat_q;
  logic signed [KW-1:0]          orkey_q, omin_q, omax_q;
  logic [PAYLOAD_BITS-1:0]       orpay_q;
  logic [CntW-1:0]               ocnt_q;

  logic                 accept, full, empty, out_load;
  logic signed [KW-1:0] last_key;
  logic [PAYLOAD_BITS-1:0] last_pay;
  logic [CntW+depq_pkg::COUNT_W-1:0] cnt_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign full     = (count_q == CntW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign out_load = pend_q && (!oval_q || out_ready_i);

  assign ctrl.ins = accept && (mode_i == depq_pkg::MODE_INSERT) && !full;
  assign ctrl.shl = accept && (mode_i == depq_pkg::MODE_DEL_MIN) && !empty;

  // A cell is occupied when its index is below the count; the last occupied
  // cell is the one whose right neighbor is free.
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                          left_lt;
      logic signed [KW-1:0]          left_key, right_key;
      logic [PAYLOAD_BITS-1:0]       left_pay, right_pay;

      assign cell_valid[gi] = (CntW'(gi) < count_q);

      if (gi == 0) begin : g_head
        // The head of the chain behaves as if a smaller key sat before it.
        assign left_lt  = 1'b1;
        assign left_key = key_i;
        assign left_pay = payload_i;
      end else begin : g_mid
        assign left_lt  = cell_lt[gi-1];
        assign left_key = cell_key[gi-1];
        assign left_pay = cell_pay[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_key      = cell_key[gi];
        assign right_pay      = cell_pay[gi];
        assign cell_last[gi]  = cell_valid[gi];
      end else begin : g_body
        assign right_key      = cell_key[gi+1];
        assign right_pay      = cell_pay[gi+1];
        assign cell_last[gi]  = cell_valid[gi] && !cell_valid[gi+1];
      end

      depq_cell #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .valid_i    (cell_valid[gi]),
        .new_key_i  (key_i),
        .new_pay_i  (payload_i),
        .left_lt_i  (left_lt),
        .left_key_i (left_key),
        .left_pay_i (left_pay),
        .right_key_i(right_key),
        .right_pay_i(right_pay),
        .lt_o       (cell_lt[gi]),
        .key_o      (cell_key[gi]),
        .pay_o      (cell_pay[gi])
      );
    end
  endgenerate

  // At most one cell is flagged last, so an OR over masked cells selects it.
  always_comb begin
    last_key = '0;
    last_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      last_key = last_key | (cell_key[i] & {KW{cell_last[i]}});
      last_pay = last_pay | (cell_pay[i] & {PAYLOAD_BITS{cell_last[i]}});
    end
  end

  // Update stage: status, removed entry and the new count.
  always_comb begin
    count_d = count_q;
    pend_d  = pend_q;
    stat_d  = stat_q;
    rkey_d  = rkey_q;
    rpay_d  = rpay_q;
    if (out_load) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
      stat_d = depq_pkg::STATUS_OK;
      rkey_d = '0;
      rpay_d = '0;
      case (mode_i)
        depq_pkg::MODE_INSERT: begin
          if (full) begin
            stat_d = depq_pkg::STATUS_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        depq_pkg::MODE_DEL_MIN: begin
          if (empty) begin
            stat_d = depq_pkg::STATUS_EMPTY;
          end else begin
            rkey_d  = cell_key[0];
            rpay_d  = cell_pay[0];
            count_d = count_q - 1'b1;
          end
        end
        depq_pkg::MODE_DEL_MAX: begin
          if (empty) begin
            stat_d = depq_pkg::STATUS_EMPTY;
          end else begin
            rkey_d  = last_key;
            rpay_d  = last_pay;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          // Query leaves the store as it is.
        end
      endcase
    end
  end

  always_comb begin
    oval_d = oval_q;
    if (out_valid_o && out_ready_i) begin
      oval_d = 1'b0;
    end
    if (out_load) begin
      oval_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    rkey_q <= rkey_d;
    rpay_q <= rpay_d;
  end

  // Readout stage: the chain already holds the updated contents.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ostat_q <= stat_q;
      orkey_q <= rkey_q;
      orpay_q <= rpay_q;
      ocnt_q  <= count_q;
      omin_q  <= empty ? '0 : cell_key[0];
      omax_q  <= empty ? '0 : last_key;
    end
  end

  assign cnt_ext = {{depq_pkg::COUNT_W{1'b0}}, ocnt_q};

  assign in_ready_o        = !pend_q;
  assign out_valid_o       = oval_q;
  assign status_o          = ostat_q;
  assign removed_key_o     = orkey_q;
  assign removed_payload_o = orpay_q;
  assign entry_count_o     = cnt_ext[depq_pkg::COUNT_W-1:0];
  assign smallest_key_o    = omin_q;
  assign largest_key_o     = omax_q;

endmodule

// ===== design/depq_checker.sv =====
// ----------------------------------------------------------------------------
// depq_checker: port-level checks for the priority queue
// Watches the result channel and the reported store summary.
// ----------------------------------------------------------------------------
module depq_checker #(
  parameter int unsigned CAPACITY = depq_pkg::CAPACITY_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic        [depq_pkg::STATUS_W-1:0] status_o,
  input logic signed [depq_pkg::KEY_W-1:0]    removed_key_o,
  input logic        [depq_pkg::COUNT_W-1:0]  entry_count_o,
  input logic signed [depq_pkg::KEY_W-1:0]    smallest_key_o,
  input logic signed [depq_pkg::KEY_W-1:0]    largest_key_o
);

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped or changed while stalled");

  // A failed operation removes nothing.
  a_fail_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != depq_pkg::STATUS_OK) |-> removed_key_o == '0)
    else $error("failed operation reports a removed key");

  // An empty store reports zero bounds.
  a_empty_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (entry_count_o == '0) |->
      (smallest_key_o == '0) && (largest_key_o == '0))
    else $error("empty store reports nonzero bounds");

  // The store stays sorted: its smallest key never exceeds its largest.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> smallest_key_o <= largest_key_o)
    else $error("smallest key above largest key");

  // An insert is reported refused as full only when the count equals the capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == depq_pkg::STATUS_FULL) |->
      entry_count_o == depq_pkg::COUNT_W'(CAPACITY))
    else $error("insert refused while store not full");

endmodule

bind double_ended_priority_queue_top depq_checker #(
  .CAPACITY(CAPACITY)
) u_depq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .removed_key_o (removed_key_o),
  .entry_count_o (entry_count_o),
  .smallest_key_o(smallest_key_o),
  .largest_key_o (largest_key_o)
);
